FILE: rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// shared constants and controller/datapath handshake types for the gcd/lcm unit
// ----------------------------------------------------------------------------
package gcd_pkg;

  // fixed field widths of the stream words
  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned ANSWER_W      = 64;
  localparam int unsigned OPERAND_W_DEF = 32;

  // opcode values
  localparam logic OP_GCD = 1'b0;
  localparam logic OP_LCM = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;        // capture operands, opcode and zero flag
    logic div_mod;     // start x mod y
    logic div_lcm;     // start a div gcd
    logic div_step;    // one restoring division step
    logic gcd_update;  // x <= y, y <= remainder
    logic mul;         // answer <= quotient * b
    logic res_gcd;     // answer <= gcd
    logic res_zero;    // answer <= 0, both_zero set
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic both_zero;
    logic y_zero;
    logic div_last;
    logic op;
  } sts_t;

endpackage

FILE: rtl/gcd_datapath.sv
// ----------------------------------------------------------------------------
// gcd_datapath
// operand registers, shared restoring divider and the lcm multiplier
// ----------------------------------------------------------------------------
module gcd_datapath #(
  parameter int unsigned OPERAND_WIDTH = gcd_pkg::OPERAND_W_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gcd_pkg::cmd_t                  cmd,
  output gcd_pkg::sts_t                  sts,
  input  logic                           op_in,
  input  logic [gcd_pkg::FIELD_W-1:0]    a_in,
  input  logic [gcd_pkg::FIELD_W-1:0]    b_in,
  output logic [gcd_pkg::ANSWER_W-1:0]   answer,
  output logic                           both_zero
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic [W-1:0]                a_r, b_r, x_r, y_r;
  logic [W-1:0]                d_r, dv_r, rem_r;
  logic [CW-1:0]               cnt_r;
  logic                        op_r, bz_r;
  logic [gcd_pkg::ANSWER_W-1:0] ans_r;
  logic                        zf_r;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;
  logic [2*W-1:0] prod;

  // restoring division step: remainder shifts in the next dividend bit
  assign trial = {rem_r, d_r[W-1]};
  assign diff  = trial - {1'b0, dv_r};
  assign ge    = (trial >= {1'b0, dv_r});
  assign prod  = d_r * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      if (cmd.div_mod || cmd.div_lcm) begin
        cnt_r <= CNT_LAST;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r  <= a_in[W-1:0];
      b_r  <= b_in[W-1:0];
      x_r  <= a_in[W-1:0];
      y_r  <= b_in[W-1:0];
      op_r <= op_in;
      bz_r <= (a_in[W-1:0] == '0) && (b_in[W-1:0] == '0);
      zf_r <= 1'b0;
    end
    if (cmd.div_mod) begin
      d_r   <= x_r;
      dv_r  <= y_r;
      rem_r <= '0;
    end else if (cmd.div_lcm) begin
      d_r   <= a_r;
      dv_r  <= x_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      d_r   <= {d_r[W-2:0], ge};
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
    end
    if (cmd.gcd_update) begin
      x_r <= y_r;
      y_r <= rem_r;
    end
    if (cmd.mul) begin
      ans_r <= gcd_pkg::ANSWER_W'(prod);
    end else if (cmd.res_gcd) begin
      ans_r <= gcd_pkg::ANSWER_W'(x_r);
    end else if (cmd.res_zero) begin
      ans_r <= '0;
      zf_r  <= 1'b1;
    end
  end

  assign sts.both_zero = bz_r;
  assign sts.y_zero    = (y_r == '0);
  assign sts.div_last  = (cnt_r == '0);
  assign sts.op        = op_r;

  assign answer    = ans_r;
  assign both_zero = zf_r;

endmodule

FILE: rtl/gcd_ctrl.sv
// ----------------------------------------------------------------------------
// gcd_ctrl
// sequencer for the euclid loop, the lcm divide and the multiply
// ----------------------------------------------------------------------------
module gcd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_free,
  output logic          out_load,
  input  gcd_pkg::sts_t sts,
  output gcd_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_UPD   = 6'b001000,
    S_MUL   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   lcm_r, lcm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lcm_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lcm_r   <= lcm_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lcm_nxt   = lcm_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.both_zero) begin
          cmd.res_zero = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.y_zero) begin
          if (sts.op == gcd_pkg::OP_GCD) begin
            cmd.res_gcd = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            cmd.div_lcm = 1'b1;
            lcm_nxt     = 1'b1;
            state_nxt   = S_DIV;
          end
        end else begin
          cmd.div_mod = 1'b1;
          lcm_nxt     = 1'b0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = lcm_r ? S_MUL : S_UPD;
        end
      end
      S_UPD: begin
        cmd.gcd_update = 1'b1;
        state_nxt      = S_CHECK;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// greatest common divisor / least common multiple of two unsigned operands
// ----------------------------------------------------------------------------
// One word in gives one word out. The gcd comes from Euclid's loop, each
// remainder taken by a shared restoring divider that retires one quotient bit
// per cycle; a remainder step is the divide, then the register swap and the
// zero test. The lcm opcode adds one more divide (a / gcd) and a multiply
// into the output register. With both operands zero the result is answer 0
// with both_zero set. Items are worked one at a time; the next word is taken
// as soon as the previous result sits in the output register, even while
// that result still waits for out_tready.
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = gcd_pkg::OPERAND_W_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] a_value, [63:32] b_value
  input  logic [0:0]  in_tuser,   // [0] opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] answer
  output logic [0:0]  out_tuser   // [0] both_zero
);

  gcd_pkg::cmd_t cmd;
  gcd_pkg::sts_t sts;

  logic                         out_load;
  logic                         out_free;
  logic [gcd_pkg::ANSWER_W-1:0] answer;
  logic                         both_zero;

  // output register parting the two sides
  logic                         out_valid_r;
  logic [gcd_pkg::ANSWER_W-1:0] out_data_r;
  logic                         out_zero_r;

  assign out_free = !out_valid_r || out_tready;

  gcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_free (out_free),
    .out_load (out_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  gcd_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .op_in     (in_tuser[0]),
    .a_in      (in_tdata[31:0]),
    .b_in      (in_tdata[63:32]),
    .answer    (answer),
    .both_zero (both_zero)
  );

  // valid flag held in reset; data registers need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= answer;
      out_zero_r <= both_zero;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_zero_r;

endmodule
